/* rtl/uhr_pkg.sv */
// ----------------------------------------------------------------------------
// uhr_pkg: shared types and constants of the undo history ring
// Command and action codes, the controller state type and the RISC-V
// opcode and funct3 values that decide how an instruction is undone.
// ----------------------------------------------------------------------------
package uhr_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_APPLY = 2'd2,
    CMD_NONE  = 2'd3
  } uhr_cmd_t;

  typedef enum logic [2:0] {
    ACT_PUSHED  = 3'd0,
    ACT_FETCH   = 3'd1,
    ACT_REG     = 3'd2,
    ACT_MEM     = 3'd3,
    ACT_NOTHING = 3'd4,
    ACT_EMPTY   = 3'd5
  } uhr_action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } uhr_state_t;

  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [2:0] F3_BYTE    = 3'b000;
  localparam logic [2:0] F3_HALF    = 3'b001;

  localparam logic [2:0] BYTES_ONE  = 3'd1;
  localparam logic [2:0] BYTES_TWO  = 3'd2;
  localparam logic [2:0] BYTES_FOUR = 3'd4;

endpackage

/* rtl/undo_history_ring.sv */
// ----------------------------------------------------------------------------
// undo_history_ring: undo history for a RISC-V instruction interpreter
// Ring of (instruction address, overwritten value) pairs with pop and
// apply commands that tell the interpreter how to undo one instruction.
// ----------------------------------------------------------------------------
// Usage. A command beat is taken at a rising edge where start is high and
// busy is low. Push stores in_instr_address and in_old_value as the newest
// entry; when the ring already holds DEPTH-1 entries the oldest one is
// dropped. Pop returns the newest address as a fetch request, or an empty
// error when nothing is held. Apply takes the instruction word fetched at
// that address plus the current rs1 value and reports a register restore,
// a memory restore (rs1 plus the S-immediate, 1, 2 or 4 bytes) or nothing.
// Each command yields exactly one result beat, shown for one cycle with
// out_valid high; the receiver cannot stall, so it must take every beat.
// Timing: push, apply, an empty pop and the unused command code give their
// result in the cycle after acceptance and busy stays low, so one such
// command per cycle is taken. A pop of a held entry reads the history RAM,
// whose read data is registered, so busy is high for one cycle and the
// result passes the RAM read register and then the output register.
// Reset clears the pointers (ring empty) and the last popped entry. The
// RAM itself is not cleared; the pointers never let a slot be read before
// it was written.
// ----------------------------------------------------------------------------
module undo_history_ring
  import uhr_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_instr_address,
  input  logic [31:0] in_old_value,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_base_value,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [31:0] out_target_address,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_restore_value,
  output logic [2:0]  out_store_bytes,
  output logic [31:0] out_resume_address
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  // Controller state and ring pointers. The oldest pointer marks the slot
  // before the oldest entry, so equal pointers mean an empty ring.
  uhr_state_t      state_r, state_nxt;
  logic [PW-1:0]   newest_ptr_r, newest_ptr_nxt;
  logic [PW-1:0]   oldest_ptr_r, oldest_ptr_nxt;
  logic [31:0]     popped_address_r, popped_address_nxt;
  logic [31:0]     popped_value_r, popped_value_nxt;

  // Registered result beat.
  logic            out_valid_r, out_valid_nxt;
  uhr_action_t     out_action_r, out_action_nxt;
  logic [31:0]     out_target_r, out_target_nxt;
  logic [4:0]      out_reg_r, out_reg_nxt;
  logic [31:0]     out_rval_r, out_rval_nxt;
  logic [2:0]      out_bytes_r, out_bytes_nxt;
  logic [31:0]     out_resume_r, out_resume_nxt;

  logic            accept;
  uhr_cmd_t        cmd;
  logic            ring_empty;
  logic [PW-1:0]   newest_next, oldest_next, newest_prev;
  logic            ram_we, ram_re;
  logic [63:0]     ram_rdata;

  // Fields of the fetched instruction used by apply.
  logic [6:0]      opcode;
  logic [4:0]      rd;
  logic [2:0]      funct3;
  logic [31:0]     store_imm;

  assign accept      = start && !busy;
  assign cmd         = uhr_cmd_t'(in_command);
  assign ring_empty  = (newest_ptr_r == oldest_ptr_r);
  assign newest_next = (newest_ptr_r == LAST) ? '0 : newest_ptr_r + PW'(1);
  assign oldest_next = (oldest_ptr_r == LAST) ? '0 : oldest_ptr_r + PW'(1);
  assign newest_prev = (newest_ptr_r == '0) ? LAST : newest_ptr_r - PW'(1);

  assign opcode    = in_instr_word[6:0];
  assign rd        = in_instr_word[11:7];
  assign funct3    = in_instr_word[14:12];
  assign store_imm = {{20{in_instr_word[31]}}, in_instr_word[31:25], in_instr_word[11:7]};

  // History storage: {address, old value} per slot. A push writes the slot
  // after the newest; a pop reads the newest slot. Both never overlap on the
  // same slot in one cycle, and a pop after a push sees the written data.
  uhr_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (newest_next),
    .wdata ({in_instr_address, in_old_value}),
    .re    (ram_re),
    .raddr (newest_ptr_r),
    .rdata (ram_rdata)
  );

  // Next state of the controller: only a pop of a held entry passes through
  // the read state while the RAM read data arrives.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && cmd == CMD_POP && !ring_empty) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    busy   = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ram_we = accept && cmd == CMD_PUSH;
        ram_re = accept && cmd == CMD_POP && !ring_empty;
      end
      ST_READ: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Pointer and popped-entry updates. The newest pointer steps back when
  // the pop is accepted; the popped pair is captured when the read returns.
  always_comb begin
    newest_ptr_nxt     = newest_ptr_r;
    oldest_ptr_nxt     = oldest_ptr_r;
    popped_address_nxt = popped_address_r;
    popped_value_nxt   = popped_value_r;
    if (ram_we) begin
      newest_ptr_nxt = newest_next;
      if (newest_next == oldest_ptr_r) begin
        oldest_ptr_nxt = oldest_next;
      end
    end
    if (ram_re) begin
      newest_ptr_nxt = newest_prev;
    end
    if (state_r == ST_READ) begin
      popped_address_nxt = ram_rdata[63:32];
      popped_value_nxt   = ram_rdata[31:0];
    end
  end

  // Result beat. Fields that mean nothing for the action are zero.
  always_comb begin
    out_valid_nxt  = 1'b0;
    out_action_nxt = ACT_NOTHING;
    out_target_nxt = '0;
    out_reg_nxt    = '0;
    out_rval_nxt   = '0;
    out_bytes_nxt  = '0;
    out_resume_nxt = '0;
    if (state_r == ST_READ) begin
      out_valid_nxt  = 1'b1;
      out_action_nxt = ACT_FETCH;
      out_target_nxt = ram_rdata[63:32];
    end else if (accept) begin
      unique case (cmd)
        CMD_PUSH: begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = ACT_PUSHED;
        end
        CMD_POP: begin
          // A held entry is reported once the read returns.
          out_valid_nxt  = ring_empty;
          out_action_nxt = ACT_EMPTY;
        end
        CMD_APPLY: begin
          out_valid_nxt  = 1'b1;
          out_resume_nxt = popped_address_r;
          priority if (opcode == OPC_BRANCH) begin
            out_action_nxt = ACT_NOTHING;
          end else if (opcode == OPC_STORE) begin
            out_action_nxt = ACT_MEM;
            out_target_nxt = in_base_value + store_imm;
            out_rval_nxt   = popped_value_r;
            out_bytes_nxt  = (funct3 == F3_BYTE) ? BYTES_ONE :
                             (funct3 == F3_HALF) ? BYTES_TWO : BYTES_FOUR;
          end else if (rd != 5'd0) begin
            out_action_nxt = ACT_REG;
            out_reg_nxt    = rd;
            out_rval_nxt   = popped_value_r;
          end else begin
            out_action_nxt = ACT_NOTHING;
          end
        end
        CMD_NONE: begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = ACT_NOTHING;
        end
        default: begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = ACT_NOTHING;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      newest_ptr_r     <= '0;
      oldest_ptr_r     <= '0;
      popped_address_r <= '0;
      popped_value_r   <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      newest_ptr_r     <= newest_ptr_nxt;
      oldest_ptr_r     <= oldest_ptr_nxt;
      popped_address_r <= popped_address_nxt;
      popped_value_r   <= popped_value_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_action_r <= out_action_nxt;
    out_target_r <= out_target_nxt;
    out_reg_r    <= out_reg_nxt;
    out_rval_r   <= out_rval_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_resume_r <= out_resume_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_target_address = out_target_r;
  assign out_reg_index      = out_reg_r;
  assign out_restore_value  = out_rval_r;
  assign out_store_bytes    = out_bytes_r;
  assign out_resume_address = out_resume_r;

  // The read wait always ends in a fetch request beat.
  a_read_gives_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> out_valid_r && out_action_r == ACT_FETCH)
    else $error("pop read did not produce a fetch beat");

  // A pop of an empty ring answers with the error in the next cycle.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd == CMD_POP && ring_empty |=> out_valid_r && out_action_r == ACT_EMPTY)
    else $error("empty pop did not report the empty error");

  // Every other command gives its beat in the next cycle.
  a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd != CMD_POP |=> out_valid_r)
    else $error("missing result beat");

  // Pointers stay inside the ring.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    newest_ptr_r <= LAST && oldest_ptr_r <= LAST)
    else $error("ring pointer out of range");

endmodule

/* rtl/uhr_ram.sv */
// ----------------------------------------------------------------------------
// uhr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module uhr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
